[src/vn_pkg.sv]
// Shared constants for the vector normalize pipeline.
package vn_pkg;

  localparam int LANES          = 3;
  localparam int DEF_COMP_WIDTH = 16;
  localparam int OUT_W          = 16;
  // Quotient bits resolved by the digit stages (result magnitude up to 2^14).
  localparam int Q_BITS         = 15;
  // Numerator scale: (a * 2^15)^2.
  localparam int NUM_SHIFT      = 30;

  // Width of the wide comparison datapath for a given component width.
  function automatic int wide_w(input int comp_w);
    return 2 * comp_w + 34;
  endfunction

endpackage

[src/vn_prep.sv]
// Front stages: sign split, squares, squared length and numerators.
module vn_prep import vn_pkg::*; #(
  parameter int COMP_WIDTH = DEF_COMP_WIDTH,
  parameter int WIDE       = wide_w(COMP_WIDTH)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              valid_in,
  input  logic [LANES-1:0][COMP_WIDTH-1:0]  comp,
  output logic                              valid_out,
  output logic                              zero,
  output logic [LANES-1:0]                  neg,
  output logic [WIDE-1:0]                   s,
  output logic [LANES-1:0][WIDE-1:0]        r
);

  logic                                a_valid;
  logic [LANES-1:0]                    a_neg;
  logic [LANES-1:0][2*COMP_WIDTH-1:0]  a_sq;
  logic [LANES-1:0][COMP_WIDTH-1:0]    mag;
  logic [WIDE-1:0]                     s_next;

  // Take magnitudes of the two's complement components
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      mag[i] = comp[i][COMP_WIDTH-1] ? (~comp[i] + COMP_WIDTH'(1)) : comp[i];
    end
  end

  // Sum the squares
  always_comb begin
    s_next = '0;
    for (int i = 0; i < LANES; i++) begin
      s_next = s_next + WIDE'(a_sq[i]);
    end
  end

  // Stage A: square each magnitude
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= valid_in;
    end
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        a_neg[i] <= comp[i][COMP_WIDTH-1];
        a_sq[i]  <= mag[i] * mag[i];
      end
    end
  end

  // Stage B: squared length, scaled numerators, zero test
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= a_valid;
    end
    if (en) begin
      neg  <= a_neg;
      s    <= s_next;
      zero <= (s_next == '0);
      for (int i = 0; i < LANES; i++) begin
        r[i] <= WIDE'(a_sq[i]) << NUM_SHIFT;
      end
    end
  end

endmodule

[src/vn_digit.sv]
// One quotient digit stage: tests one bit of the rounded quotient per lane.
module vn_digit import vn_pkg::*; #(
  parameter int WIDE = wide_w(DEF_COMP_WIDTH),
  parameter int BIT  = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         valid_in,
  input  logic                         zero_in,
  input  logic [LANES-1:0]             neg_in,
  input  logic [WIDE-1:0]              s_in,
  input  logic [LANES-1:0][WIDE-1:0]   r_in,
  input  logic [LANES-1:0][Q_BITS-1:0] q_in,
  input  logic [LANES-1:0][WIDE-1:0]   p_in,
  input  logic [LANES-1:0][WIDE-1:0]   qs_in,
  output logic                         valid_out,
  output logic                         zero_out,
  output logic [LANES-1:0]             neg_out,
  output logic [WIDE-1:0]              s_out,
  output logic [LANES-1:0][WIDE-1:0]   r_out,
  output logic [LANES-1:0][Q_BITS-1:0] q_out,
  output logic [LANES-1:0][WIDE-1:0]   p_out,
  output logic [LANES-1:0][WIDE-1:0]   qs_out
);

  logic [LANES-1:0][WIDE-1:0] p_try;
  logic [LANES-1:0][WIDE-1:0] qs_try;
  logic [LANES-1:0][WIDE-1:0] lhs;
  logic [LANES-1:0]           take;

  // Candidate q' = q + 2^BIT; keep it when (2q'-1)^2 * s <= r
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      p_try[i]  = p_in[i] + (qs_in[i] << (BIT + 1)) + (s_in << (2 * BIT));
      qs_try[i] = qs_in[i] + (s_in << BIT);
      lhs[i]    = (p_try[i] << 2) - (qs_try[i] << 2) + s_in;
      take[i]   = (lhs[i] <= r_in[i]);
    end
  end

  // Advance the lane state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
    if (en) begin
      zero_out <= zero_in;
      neg_out  <= neg_in;
      s_out    <= s_in;
      r_out    <= r_in;
      for (int i = 0; i < LANES; i++) begin
        q_out[i]  <= take[i] ? (q_in[i] | (Q_BITS'(1) << BIT)) : q_in[i];
        p_out[i]  <= take[i] ? p_try[i] : p_in[i];
        qs_out[i] <= take[i] ? qs_try[i] : qs_in[i];
      end
    end
  end

endmodule

[src/vector3_normalize_unit.sv]
// Top level of the three-component vector normalize pipeline.
//
//   channel   dir   tdata (low bit up)                     tuser
//   s_axis    in    in_x, in_y, in_z (COMP_WIDTH each)      -
//   m_axis    out   norm_x, norm_y, norm_z (16 each)        zero_vector
//
// One vector per clock, through two front stages (square, sum),
// fifteen quotient digit stages (one rounded-quotient bit each), one output
// register. The whole pipeline advances together and halts while the output
// beat is held. Reset clears the valid bits only.
module vector3_normalize_unit import vn_pkg::*; #(
  parameter int COMP_WIDTH = DEF_COMP_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // in_x, in_y, in_z, zero pad to whole bytes
  input  logic [((LANES*COMP_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // norm_x, norm_y, norm_z
  output logic [LANES*OUT_W-1:0]                m_tdata,
  // zero_vector
  output logic                                  m_tuser
);

  localparam int WIDE = wide_w(COMP_WIDTH);

  logic                                en;
  logic [LANES-1:0][COMP_WIDTH-1:0]    comp;

  logic                         st_valid [Q_BITS+1];
  logic                         st_zero  [Q_BITS+1];
  logic [LANES-1:0]             st_neg   [Q_BITS+1];
  logic [WIDE-1:0]              st_s     [Q_BITS+1];
  logic [LANES-1:0][WIDE-1:0]   st_r     [Q_BITS+1];
  logic [LANES-1:0][Q_BITS-1:0] st_q     [Q_BITS+1];
  logic [LANES-1:0][WIDE-1:0]   st_p     [Q_BITS+1];
  logic [LANES-1:0][WIDE-1:0]   st_qs    [Q_BITS+1];

  logic [LANES-1:0][OUT_W-1:0]  res_next;

  // Advance whenever the output register is free or being drained
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      comp[i] = s_tdata[i*COMP_WIDTH +: COMP_WIDTH];
    end
  end

  vn_prep #(.COMP_WIDTH(COMP_WIDTH), .WIDE(WIDE)) u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (s_tvalid),
    .comp      (comp),
    .valid_out (st_valid[0]),
    .zero      (st_zero[0]),
    .neg       (st_neg[0]),
    .s         (st_s[0]),
    .r         (st_r[0])
  );

  assign st_q[0]  = '0;
  assign st_p[0]  = '0;
  assign st_qs[0] = '0;

  // Resolve quotient bits from the top down
  for (genvar j = 0; j < Q_BITS; j++) begin : g_digit
    vn_digit #(.WIDE(WIDE), .BIT(Q_BITS - 1 - j)) u_digit (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .valid_in  (st_valid[j]),
      .zero_in   (st_zero[j]),
      .neg_in    (st_neg[j]),
      .s_in      (st_s[j]),
      .r_in      (st_r[j]),
      .q_in      (st_q[j]),
      .p_in      (st_p[j]),
      .qs_in     (st_qs[j]),
      .valid_out (st_valid[j+1]),
      .zero_out  (st_zero[j+1]),
      .neg_out   (st_neg[j+1]),
      .s_out     (st_s[j+1]),
      .r_out     (st_r[j+1]),
      .q_out     (st_q[j+1]),
      .p_out     (st_p[j+1]),
      .qs_out    (st_qs[j+1])
    );
  end

  // Apply signs; a zero vector passes through as zeros
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      if (st_zero[Q_BITS]) begin
        res_next[i] = '0;
      end else if (st_neg[Q_BITS][i]) begin
        res_next[i] = OUT_W'(0) - OUT_W'(st_q[Q_BITS][i]);
      end else begin
        res_next[i] = OUT_W'(st_q[Q_BITS][i]);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= st_valid[Q_BITS];
    end
    if (en) begin
      m_tdata <= res_next;
      m_tuser <= st_zero[Q_BITS];
    end
  end

  // A zero-vector beat carries all-zero components
  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("zero vector beat with nonzero data");

  // Unit vector components never exceed one in magnitude
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[15:0])  <= 16384 && $signed(m_tdata[15:0])  >= -16384 &&
                  $signed(m_tdata[31:16]) <= 16384 && $signed(m_tdata[31:16]) >= -16384 &&
                  $signed(m_tdata[47:32]) <= 16384 && $signed(m_tdata[47:32]) >= -16384))
    else $error("normalized component out of range");

  // A held output beat stalls the whole pipeline
  a_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(st_valid[0]) && $stable(st_q[Q_BITS]))
    else $error("pipeline moved during output stall");

endmodule

[dv/vector3_normalize_unit_tb.sv]
// Testbench for vector3_normalize_unit: random and directed vectors checked against a predictor.
module vector3_normalize_unit_tb;
  import vn_pkg::*;

  localparam int CW   = DEF_COMP_WIDTH;
  localparam int DW   = ((LANES*CW+7)/8)*8;
  localparam int UNIT = 16384;

  typedef struct packed {
    logic [OUT_W-1:0] nx;
    logic [OUT_W-1:0] ny;
    logic [OUT_W-1:0] nz;
    logic             zero;
  } unit_vec_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [DW-1:0] s_tdata = '0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [LANES*OUT_W-1:0] m_tdata;
  logic          m_tuser;

  unit_vec_t expected_units[$];
  int        error_count = 0;
  bit        send_idle = 1'b1;
  bit        recv_idle = 1'b1;

  vector3_normalize_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #2 clk = ~clk;

  // Rounded a*2^14/sqrt(s): largest q with (2q-1)^2 * s <= (a*2^15)^2.
  function automatic logic [OUT_W-1:0] rounded_ratio(input logic [CW-1:0] a,
                                                     input logic [63:0] s);
    logic [127:0] num;
    logic [127:0] lhs;
    logic [63:0]  k;
    int lo;
    int hi;
    int mid;
    num = ({64'd0, a} << 15) * ({64'd0, a} << 15);
    lo = 0;
    hi = UNIT;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      k = 64'(2 * mid - 1);
      lhs = {64'd0, k * k} * {64'd0, s};
      if (lhs <= num) lo = mid;
      else hi = mid - 1;
    end
    return lo[OUT_W-1:0];
  endfunction

  function automatic unit_vec_t normalize_vec(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                              input logic [CW-1:0] z);
    logic [CW-1:0] comp[3];
    logic [CW-1:0] mag[3];
    logic [OUT_W-1:0] q[3];
    logic [63:0] s;
    unit_vec_t r;
    comp[0] = x; comp[1] = y; comp[2] = z;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = comp[i][CW-1] ? (~comp[i] + 1'b1) : comp[i];
      s += {48'd0, mag[i]} * {48'd0, mag[i]};
    end
    if (s == 0) return '{nx: '0, ny: '0, nz: '0, zero: 1'b1};
    for (int i = 0; i < 3; i++) begin
      q[i] = rounded_ratio(mag[i], s);
      if (comp[i][CW-1]) q[i] = -q[i];
    end
    r = '{nx: q[0], ny: q[1], nz: q[2], zero: 1'b0};
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Send one vector beat, with optional random gap before it.
  task automatic send_vector(input logic [CW-1:0] x, input logic [CW-1:0] y,
                             input logic [CW-1:0] z);
    if (send_idle && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= DW'({z, y, x});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_units.push_back(normalize_vec(x, y, z));
  endtask

  task automatic idle_sender();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Drive receiver ready at random, or always high once full-rate mode begins.
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (!recv_idle) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(0, 4) != 0);
  end

  // Check each output beat against the oldest expectation.
  always @(posedge clk) begin
    unit_vec_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_units.size() == 0) begin
        report_mismatch("unexpected beat", 0, 0);
      end else begin
        want = expected_units.pop_front();
        if (m_tdata[15:0] !== want.nx)
          report_mismatch("norm_x", $signed(m_tdata[15:0]), $signed(want.nx));
        if (m_tdata[31:16] !== want.ny)
          report_mismatch("norm_y", $signed(m_tdata[31:16]), $signed(want.ny));
        if (m_tdata[47:32] !== want.nz)
          report_mismatch("norm_z", $signed(m_tdata[47:32]), $signed(want.nz));
        if (m_tuser !== want.zero) report_mismatch("zero_vector", m_tuser, want.zero);
      end
    end
  end

  task automatic test_directed();
    logic [CW-1:0] mx;
    logic [CW-1:0] mn;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    send_vector(0, 0, 0);
    send_vector(256, 0, 0);
    send_vector(0, -256, 0);
    send_vector(0, 0, 1);
    send_vector(mn, 0, 0);
    send_vector(0, mn, 0);
    send_vector(0, 0, mn);
    send_vector(mx, 0, 0);
    send_vector(mn, mn, mn);
    send_vector(mx, mx, mx);
    send_vector(mx, mn, mx);
    send_vector(1, 1, 1);
    send_vector(-1, 1, -1);
    send_vector(3, 4, 0);
    send_vector(1, mn, 1);
    send_vector(16'hAAAA, 16'h5555, 16'hFFFF);
    send_vector(0, 0, 0);
  endtask

  task automatic test_random(input int count);
    logic [CW-1:0] v[3];
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < 3; i++) begin
        case ($urandom_range(0, 5))
          0: v[i] = '0;
          1: v[i] = CW'($urandom_range(0, 15) - 8);
          2: v[i] = $urandom_range(0, 1) ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
          default: v[i] = CW'($urandom);
        endcase
      end
      send_vector(v[0], v[1], v[2]);
    end
  endtask

  task automatic test_full_rate(input int count);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    test_random(count);
  endtask

  task automatic wait_drain();
    idle_sender();
    while (expected_units.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(1500);
    test_full_rate(300);
    wait_drain();
    if (error_count == 0) $display("** vector3_normalize_unit: PASSED **");
    else $display("** vector3_normalize_unit: FAILED **");
    $finish;
  end

  initial begin
    #2000000;
    $display("** vector3_normalize_unit: FAILED **");
    $finish;
  end

endmodule
